FILE: hw/rtl/sync_length_xor_frame_receiver_macros.svh
// Assertion macros for the sync/length/XOR frame receiver.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH
`ifndef NO_ASSERTIONS
// combinational condition checked at every clock edge outside reset
`define SLXFR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("slxfr assertion failed");
// same-cycle implication
`define SLXFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slxfr assertion failed");
// next-cycle implication
`define SLXFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slxfr assertion failed");
`else
`define SLXFR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SLXFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SLXFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/slxfr_pkg.sv
// Shared types and constants of the sync/length/XOR frame receiver.
// No dependencies; imported by every module of the block.
package slxfr_pkg;

    localparam int HDR_LEN    = 6;
    localparam int HDR_OUT    = 5;   // header bytes 1..5 passed on
    localparam int CHECK_LEN  = 2;
    localparam int QDEPTH     = 8;   // holds the backlog left by a header burst
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [7:0]  CFG_SYNC      = 8'd0;
    localparam logic [7:0]  CFG_LIMIT     = 8'd1;
    localparam logic [7:0]  SYNC_RESET    = 8'd30;
    localparam logic [15:0] LIMIT_RESET   = 16'd122;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    // one queue entry: a single result, or a burst of the five header bytes
    typedef struct packed {
        logic                        hdr;
        t_kind                       kind;
        logic [7:0]                  data;
        logic [HDR_OUT-1:0][7:0]     hdr_bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: hw/rtl/slxfr_front.sv
// Front end: config registers, sync hunt, header collection, body tracking.
// Depends on slxfr_pkg; pushes result jobs into slxfr_queue.
module slxfr_front
    import slxfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ready,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    logic [7:0]  r_sync;
    logic [15:0] r_limit;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_hdr [HDR_LEN];
    logic [7:0]  n_hdr [HDR_LEN];
    logic [7:0]  w_hdr [HDR_LEN];
    logic [2:0]  r_fill, n_fill;
    logic [15:0] r_len, n_len;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_even, n_even;
    logic [7:0]  r_odd, n_odd;

    // resync candidate
    logic [7:0]  rs_hdr [HDR_LEN];
    logic [2:0]  rs_sel;
    logic [2:0]  rs_n;
    logic        rs_found;
    logic [7:0]  rs_even, rs_odd;

    logic        accept;
    logic [2:0]  fill_inc;
    logic [15:0] hdr_len;
    logic [16:0] body_end, total;
    logic [7:0]  f_even, f_odd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_stat.full;
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= SYNC_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SYNC) begin
                r_sync <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_LIMIT) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // header as it stands after this byte is written
    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            w_hdr[i] = r_hdr[i];
        end
        if (r_phase == PH_HEADER && r_fill < 3'(HDR_LEN)) begin
            w_hdr[r_fill] = i_rx_byte;
        end
    end

    // first sync byte among header bytes 1..5, shifted down, parity rebuilt
    always_comb begin
        logic [3:0] idx;
        rs_sel   = 3'd0;
        rs_found = 1'b0;
        for (int p = HDR_LEN - 1; p >= 1; p--) begin
            if (w_hdr[p] == r_sync) begin
                rs_sel   = 3'(p);
                rs_found = 1'b1;
            end
        end
        rs_n    = 3'(HDR_LEN) - rs_sel;
        rs_even = '0;
        rs_odd  = '0;
        for (int i = 0; i < HDR_LEN; i++) begin
            idx = 4'(i) + {1'b0, rs_sel};
            rs_hdr[i] = (idx < 4'(HDR_LEN)) ? w_hdr[idx[2:0]] : w_hdr[i];
            if (3'(i) < rs_n) begin
                if (i % 2 == 0) begin
                    rs_even = rs_even ^ rs_hdr[i];
                end else begin
                    rs_odd = rs_odd ^ rs_hdr[i];
                end
            end
        end
    end

    assign fill_inc = r_fill + 3'd1;
    assign hdr_len  = {w_hdr[4], w_hdr[5]};
    assign body_end = 17'(HDR_LEN) + {1'b0, r_len};
    assign total    = body_end + {16'b0, r_len[0]} + 17'(CHECK_LEN);
    assign f_even   = r_pos[0] ? r_even : (r_even ^ i_rx_byte);
    assign f_odd    = r_pos[0] ? (r_odd ^ i_rx_byte) : r_odd;

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_len   = r_len;
        n_pos   = r_pos;
        n_even  = r_even;
        n_odd   = r_odd;
        for (int i = 0; i < HDR_LEN; i++) begin
            n_hdr[i] = r_hdr[i];
        end
        o_push = 1'b0;
        o_job  = '0;

        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_fill >= 3'(HDR_LEN)) begin
                        // store already full: fall back to resync
                        for (int i = 0; i < HDR_LEN; i++) begin
                            n_hdr[i] = rs_found ? rs_hdr[i] : w_hdr[i];
                        end
                        n_len   = '0;
                        n_pos   = '0;
                        n_even  = rs_found ? rs_even : 8'd0;
                        n_odd   = rs_found ? rs_odd : 8'd0;
                        n_fill  = rs_found ? rs_n : 3'd0;
                        n_phase = rs_found ? PH_HEADER : PH_HUNT;
                    end else begin
                        for (int i = 0; i < HDR_LEN; i++) begin
                            n_hdr[i] = w_hdr[i];
                        end
                        if (r_fill[0]) begin
                            n_odd = r_odd ^ i_rx_byte;
                        end else begin
                            n_even = r_even ^ i_rx_byte;
                        end
                        n_fill = fill_inc;
                        if (fill_inc == 3'(HDR_LEN)) begin
                            o_push = 1'b1;
                            if (hdr_len > r_limit) begin
                                o_job.kind = KIND_LEN_ERR;
                                for (int i = 0; i < HDR_LEN; i++) begin
                                    n_hdr[i] = rs_found ? rs_hdr[i] : w_hdr[i];
                                end
                                n_len   = '0;
                                n_pos   = '0;
                                n_even  = rs_found ? rs_even : 8'd0;
                                n_odd   = rs_found ? rs_odd : 8'd0;
                                n_fill  = rs_found ? rs_n : 3'd0;
                                n_phase = rs_found ? PH_HEADER : PH_HUNT;
                            end else begin
                                o_job.hdr  = 1'b1;
                                o_job.kind = KIND_BYTE;
                                for (int i = 0; i < HDR_OUT; i++) begin
                                    o_job.hdr_bytes[i] = w_hdr[i + 1];
                                end
                                n_len   = hdr_len;
                                n_pos   = 17'(HDR_LEN);
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    n_even = f_even;
                    n_odd  = f_odd;
                    if (r_pos < body_end) begin
                        n_pos      = r_pos + 17'd1;
                        o_push     = 1'b1;
                        o_job.kind = KIND_BYTE;
                        o_job.data = i_rx_byte;
                    end else if (r_pos + 17'd1 < total) begin
                        // pad byte or first check byte
                        n_pos = r_pos + 17'd1;
                    end else begin
                        o_push = 1'b1;
                        if (f_even == 8'd0 && f_odd == 8'd0) begin
                            o_job.kind = KIND_GOOD;
                            n_phase    = PH_HUNT;
                            n_fill     = '0;
                            n_len      = '0;
                            n_pos      = '0;
                            n_even     = '0;
                            n_odd      = '0;
                        end else begin
                            o_job.kind = KIND_BAD;
                            for (int i = 0; i < HDR_LEN; i++) begin
                                n_hdr[i] = rs_found ? rs_hdr[i] : w_hdr[i];
                            end
                            n_len   = '0;
                            n_pos   = '0;
                            n_even  = rs_found ? rs_even : 8'd0;
                            n_odd   = rs_found ? rs_odd : 8'd0;
                            n_fill  = rs_found ? rs_n : 3'd0;
                            n_phase = rs_found ? PH_HEADER : PH_HUNT;
                        end
                    end
                end
                default: begin
                    if (i_rx_byte == r_sync) begin
                        n_hdr[0] = i_rx_byte;
                        n_fill   = 3'd1;
                        n_even   = i_rx_byte;
                        n_odd    = '0;
                        n_len    = '0;
                        n_pos    = '0;
                        n_phase  = PH_HEADER;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fill  <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_even  <= '0;
            r_odd   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_even  <= n_even;
            r_odd   <= n_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HDR_LEN; i++) begin
            r_hdr[i] <= n_hdr[i];
        end
    end

endmodule

FILE: hw/rtl/slxfr_queue.sv
// Small job FIFO between front end and result sequencer.
// Depends on slxfr_pkg (t_job, t_q_stat, QDEPTH).
module slxfr_queue
    import slxfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_stat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/slxfr_back.sv
// Result sequencer: expands jobs into results, one per output transfer.
// Depends on slxfr_pkg; fed by slxfr_queue.
module slxfr_back
    import slxfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_frame_byte,
    output logic       o_last_of_run
);

    logic       r_busy;
    t_job       r_job;
    logic [2:0] r_idx;
    logic       cur_last;
    logic       done;

    assign cur_last = r_job.hdr ? (r_idx == 3'(HDR_OUT - 1)) : 1'b1;
    assign done     = r_busy && i_ready && cur_last;
    assign o_pop    = !i_q_stat.empty && (!r_busy || done);

    assign o_valid       = r_busy;
    assign o_kind        = r_job.kind;
    assign o_frame_byte  = r_job.hdr ? r_job.hdr_bytes[r_idx] : r_job.data;
    assign o_last_of_run = cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (cur_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule

FILE: hw/rtl/sync_length_xor_frame_receiver.sv
// Top level of the sync/length/XOR frame receiver.
// Depends on slxfr_pkg, slxfr_front, slxfr_queue, slxfr_back and the macro header.
//
// Usage:
//  - Input channel (i_valid/o_ready, i_rx_byte): one received byte per transfer.
//  - Output channel (o_valid/i_ready): o_kind, o_frame_byte, o_last_of_run.
//    kind 0 is a header/payload byte, 1 good end, 2 bad checksum end,
//    3 length error. o_last_of_run marks the final result of one input byte.
//  - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data):
//    index 0 sync byte, index 1 length limit; other indexes ignored. Always
//    ready; write only while idle.
//  - Path: jobs are registered in the job queue, then in the result sequencer.
//  - Throughput: one input byte per cycle while o_ready is high, one result per
//    cycle while i_ready is high. A completed header makes a five-result burst;
//    the payload bytes that arrive meanwhile pile up to five jobs, absorbed by
//    the 8-entry job queue and drained during pad, check and next header bytes.
//  - Output stall: the queue fills and o_ready drops; nothing is lost.
//  - Reset (i_rst_n low, synchronous): hunting for sync, queue empty, config
//    back to sync 30 and limit 122. No clearing pass.
`include "sync_length_xor_frame_receiver_macros.svh"
module sync_length_xor_frame_receiver
    import slxfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_of_run
);

    // front -> queue
    logic    q_push;
    t_job    q_in_job;
    // queue -> back
    logic    q_pop;
    t_job    q_out_job;
    t_q_stat q_stat;
    // output classification for the checks below
    logic    out_marker;
    logic    in_burst;

    // state tracking and job generation
    slxfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .o_ready     (o_ready),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_job       (q_in_job)
    );

    // decouples the byte stream from output stalls
    slxfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_stat  (q_stat)
    );

    // expands header bursts into single results
    slxfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_job         (q_out_job),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_frame_byte  (o_frame_byte),
        .o_last_of_run (o_last_of_run)
    );

    assign out_marker = o_valid && (o_kind != KIND_BYTE);
    assign in_burst   = o_valid && !o_last_of_run;

    // a job is never generated while the queue has no room
    `SLXFR_ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, q_push, !q_stat.full)
    // only frame bytes carry data
    `SLXFR_ASSERT_IMPLIES(a_marker_zero, i_clk, i_rst_n, out_marker, o_frame_byte == 8'd0)
    // only a header burst has non-final results
    `SLXFR_ASSERT_IMPLIES(a_burst_kind, i_clk, i_rst_n, in_burst, o_kind == KIND_BYTE)
    // a result inside a burst is followed by more output
    `SLXFR_ASSERT_NEXT(a_burst_cont, i_clk, i_rst_n, in_burst, o_valid)

endmodule

FILE: bench/frame_receiver_checker.sv
// Result checker for the sync/length/XOR frame receiver: follows the received
// bytes and config writes, predicts every result and compares it on transfer.
// Depends on slxfr_pkg for the phase and result-kind enums and the reset config.
module frame_receiver_checker
    import slxfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_HI_AT    = 4;   // header offset of the length high byte

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_frame_result;

    t_frame_result results_due [$];
    t_frame_result want;
    int            fail_count = 0;

    // configuration copy
    logic [7:0]  sync_cfg;
    logic [15:0] limit_cfg;

    // deframer state
    t_phase      rx_phase;
    logic [7:0]  hdr_bytes [HDR_LEN];
    int unsigned hdr_fill;
    logic [15:0] body_len;
    int unsigned body_pos;
    logic [7:0]  even_xor;
    logic [7:0]  odd_xor;

    task automatic push_result(input t_kind kind, input logic [7:0] data, input logic last);
        t_frame_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        results_due.push_back(r);
    endtask

    task automatic fold_byte(input int unsigned pos, input logic [7:0] b);
        if (pos[0])
            odd_xor ^= b;
        else
            even_xor ^= b;
    endtask

    task automatic clear_frame();
        rx_phase = PH_HUNT;
        hdr_fill = 0;
        body_len = '0;
        body_pos = 0;
        even_xor = '0;
        odd_xor  = '0;
    endtask

    // after an error: restart from the first sync byte among header bytes 1..5
    task automatic rescan_header();
        int unsigned p;
        int unsigned i;
        int unsigned n;
        bit          found;
        clear_frame();
        found = 1'b0;
        for (p = 1; p < HDR_LEN && !found; p++) begin
            if (hdr_bytes[p] == sync_cfg) begin
                found = 1'b1;
                n = HDR_LEN - p;
                for (i = 0; i < n; i++) begin
                    hdr_bytes[i] = hdr_bytes[i + p];
                    fold_byte(i, hdr_bytes[i]);
                end
                hdr_fill = n;
                rx_phase = PH_HEADER;
            end
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] hdr_len;
        int unsigned frame_total;
        int unsigned i;
        case (rx_phase)
            PH_HEADER: begin
                if (hdr_fill >= HDR_LEN) begin
                    rescan_header();
                end else begin
                    hdr_bytes[hdr_fill] = b;
                    fold_byte(hdr_fill, b);
                    hdr_fill++;
                    if (hdr_fill == HDR_LEN) begin
                        hdr_len = {hdr_bytes[LEN_HI_AT], hdr_bytes[LEN_HI_AT + 1]};
                        if (hdr_len > limit_cfg) begin
                            push_result(KIND_LEN_ERR, 8'h00, 1'b1);
                            rescan_header();
                        end else begin
                            body_len = hdr_len;
                            body_pos = HDR_LEN;
                            rx_phase = PH_BODY;
                            for (i = 1; i < HDR_LEN; i++)
                                push_result(KIND_BYTE, hdr_bytes[i], i == HDR_LEN - 1);
                        end
                    end
                end
            end
            PH_BODY: begin
                frame_total = HDR_LEN + body_len + body_len[0] + CHECK_LEN;
                fold_byte(body_pos, b);
                if (body_pos < HDR_LEN + body_len) begin
                    body_pos++;
                    push_result(KIND_BYTE, b, 1'b1);
                end else if (body_pos + 1 < frame_total) begin
                    body_pos++;   // pad or first check byte
                end else if (even_xor == 8'h00 && odd_xor == 8'h00) begin
                    push_result(KIND_GOOD, 8'h00, 1'b1);
                    clear_frame();
                end else begin
                    push_result(KIND_BAD, 8'h00, 1'b1);
                    rescan_header();
                end
            end
            default: begin
                if (b == sync_cfg) begin
                    clear_frame();
                    hdr_bytes[0] = b;
                    hdr_fill = 1;
                    even_xor = b;
                    rx_phase = PH_HEADER;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_cfg  = SYNC_RESET;
            limit_cfg = LIMIT_RESET;
            clear_frame();
            foreach (hdr_bytes[k]) hdr_bytes[k] = 8'h00;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SYNC)
                    sync_cfg = i_cfg_data[7:0];
                else if (i_cfg_index == CFG_LIMIT)
                    limit_cfg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                deframe_byte(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result kind %0d byte %02h last %0b",
                             $time, i_kind, i_frame_byte, i_last_of_run);
                end else begin
                    want = results_due.pop_front();
                    if (i_kind !== want.kind || i_frame_byte !== want.data ||
                        i_last_of_run !== want.last) begin
                        fail_count++;
                        $display("%0t: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                                 $time, want.kind, want.data, want.last,
                                 i_kind, i_frame_byte, i_last_of_run);
                    end
                end
            end
        end
        o_fail_count  <= fail_count;
        o_results_due <= results_due.size();
    end

endmodule

FILE: bench/tb_top.sv
// Top of the frame receiver bench: clock, reset, byte and config stimulus, verdict.
// Depends on slxfr_pkg, sync_length_xor_frame_receiver and frame_receiver_checker.
module tb_top;
    import slxfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT      = 21;     // idle chance per cycle, each side
    localparam int          SETTLE_CYCLES = 8;      // extra wait after all results are out, kept as margin
    localparam int          STALL_LIMIT   = 2000;   // cycles with no transfer at all
    localparam int          PHASE_BYTES   = 25;     // random bytes per config setting
    localparam logic [7:0]  CFG_NONE      = 8'hFF;  // no register at this index
    localparam int          LEN_HI_AT     = 4;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [15:0] i_cfg_data  = 16'h0000;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_frame_byte;
    logic        o_last_of_run;

    int          fail_count;
    int          results_due;
    int          stall_cycles = 0;

    // stimulus-side view of the config, used to shape frames
    logic [7:0]  sync_now  = SYNC_RESET;
    logic [15:0] limit_now = LIMIT_RESET;
    logic [7:0]  line_bytes [$];     // serial bytes waiting to go out
    int unsigned bytes_sent = 0;
    bit          steady = 1'b0;      // set: neither side idles

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sync_length_xor_frame_receiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_frame_byte (o_frame_byte),
        .o_last_of_run(o_last_of_run)
    );

    frame_receiver_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_kind       (o_kind),
        .i_frame_byte (o_frame_byte),
        .i_last_of_run(o_last_of_run),
        .o_fail_count (fail_count),
        .o_results_due(results_due)
    );

    // Receiver side: back-pressure at random unless in a steady stretch.
    always @(posedge i_clk) begin
        i_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Any byte but the current sync value, so noise never opens a frame.
    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == sync_now) ? (b ^ 8'h01) : b;
    endfunction

    // Queue one frame: sync, three header bytes, big-endian length, payload,
    // pad when the length is odd, then the even and odd check bytes (header_only stops after the length).
    // sync_at (1..3) plants a sync byte inside the header, 0 for none.
    task automatic queue_frame(input logic [15:0] len, input bit bad_check,
                               input bit header_only, input int unsigned sync_at);
        int unsigned start;
        int unsigned k;
        logic [7:0]  even_chk;
        logic [7:0]  odd_chk;
        start = line_bytes.size();
        even_chk = 8'h00;
        odd_chk = 8'h00;
        line_bytes.push_back(sync_now);
        for (k = 1; k < LEN_HI_AT; k++)
            line_bytes.push_back((k == sync_at) ? sync_now : other_byte());
        line_bytes.push_back(len[15:8]);
        line_bytes.push_back(len[7:0]);
        if (!header_only) begin
            // payload and pad are both covered by the checksum
            for (k = 0; k < len + len[0]; k++)
                line_bytes.push_back(8'($urandom_range(0, 255)));
            for (k = 0; k < line_bytes.size() - start; k++) begin
                if (k[0])
                    odd_chk ^= line_bytes[start + k];
                else
                    even_chk ^= line_bytes[start + k];
            end
            if (bad_check)
                even_chk ^= 8'($urandom_range(1, 255));
            line_bytes.push_back(even_chk);
            line_bytes.push_back(odd_chk);
        end
    endtask

    // Push out every queued byte, one transfer each, with random gaps unless steady.
    task automatic send_line_bytes();
        logic [7:0] b;
        while (line_bytes.size() != 0) begin
            b = line_bytes.pop_front();
            while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_rx_byte <= b;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    // Hold the sender until every predicted result has come out, then let
    // the pipe run empty for a further idle wait that extra sets.
    task automatic wait_results_done(input int unsigned extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Register write; valid drops before the task returns, so it is never re-raised in the
    // step where it drops.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content; the rest is noise,
    // bad checksums and over-limit headers. hold_midway adds a pause for all results halfway.
    task automatic random_traffic(input int unsigned target, input bit hold_midway);
        int unsigned start;
        int unsigned pick;
        int unsigned max_len;
        int unsigned span;
        bit          held;
        start = bytes_sent;
        held = !hold_midway;
        while (bytes_sent - start < target) begin
            if (!held && bytes_sent - start >= target / 2) begin
                wait_results_done(0);
                held = 1'b1;
            end
            pick = $urandom_range(0, 9);
            max_len = (limit_now < 12) ? limit_now : 12;
            if ($urandom_range(0, 7) == 0)
                max_len = (limit_now < 40) ? limit_now : 40;
            if (pick == 0) begin
                repeat ($urandom_range(1, 3)) line_bytes.push_back(other_byte());
            end else if (pick == 1 && limit_now != 16'hFFFF) begin
                span = 65534 - limit_now;
                if (span > 500)
                    span = 500;
                // a sync planted in the header makes the rescan pick it up;
                // only with a small limit so a stray header stays short
                queue_frame(16'(limit_now + 1 + $urandom_range(0, span)), 1'b0, 1'b1,
                            (limit_now <= 200) ? $urandom_range(0, 3) : 0);
            end else if (pick == 2) begin
                queue_frame(16'($urandom_range(0, max_len)), 1'b1, 1'b0, 0);
            end else begin
                queue_frame(16'($urandom_range(0, max_len)), 1'b0, 1'b0, 0);
            end
            send_line_bytes();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset config (sync 30, limit 122).
        // Byte extremes while hunting, then a good one-byte frame with pad.
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        queue_frame(16'd1, 1'b0, 1'b0, 0);
        // Length 0xFFFF is over the limit; header byte 2 is a sync, so the
        // rescan keeps header bytes 2..5 as a new four-byte header start.
        queue_frame(16'hFFFF, 1'b0, 1'b1, 2);
        // Two zero length bytes finish that header (length 0, accepted);
        // zero check bytes leave the even XOR nonzero: bad end, back to hunt.
        repeat (4) line_bytes.push_back(8'h00);
        send_line_bytes();
        wait_results_done(SETTLE_CYCLES);

        // Sync at its top value, no effective limit, no idling on either side.
        // Includes the pause where the sender waits for all results.
        sync_now  = 8'hFF;
        limit_now = 16'hFFFF;
        write_reg(CFG_SYNC, {8'($urandom_range(0, 255)), sync_now});
        write_reg(CFG_LIMIT, limit_now);
        steady = 1'b1;
        random_traffic(PHASE_BYTES, 1'b1);
        steady = 1'b0;
        wait_results_done(SETTLE_CYCLES);

        // Sync zero and limit zero; a write to a missing register is dropped.
        sync_now  = 8'h00;
        limit_now = 16'h0000;
        write_reg(CFG_NONE, 16'hFFFF);
        write_reg(CFG_SYNC, {8'($urandom_range(0, 255)), sync_now});
        write_reg(CFG_LIMIT, limit_now);
        random_traffic(PHASE_BYTES, 1'b0);
        wait_results_done(SETTLE_CYCLES);

        // Random sync, modest limit.
        sync_now  = 8'($urandom_range(0, 255));
        limit_now = 16'($urandom_range(1, 200));
        write_reg(CFG_SYNC, {8'($urandom_range(0, 255)), sync_now});
        write_reg(CFG_LIMIT, limit_now);
        random_traffic(PHASE_BYTES, 1'b1);
        wait_results_done(SETTLE_CYCLES);

        if (fail_count == 0 && results_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/slxfr_pkg.sv
hw/rtl/slxfr_front.sv
hw/rtl/slxfr_queue.sv
hw/rtl/slxfr_back.sv
hw/rtl/sync_length_xor_frame_receiver.sv
bench/frame_receiver_checker.sv
bench/tb_top.sv
